// File: sv/rls_pkg.sv
// Package: shared types and constants of the radio link supervisor.
`timescale 1ns / 1ps

package rls_pkg;

    localparam int TIMER_BITS = 16;
    localparam int COUNT_BITS = 8;
    localparam int TMO_W      = 16;
    localparam int LIM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = 32;

    typedef enum logic [1:0] {
        MODE_UNKNOWN      = 2'd0,
        MODE_CONNECTING   = 2'd1,
        MODE_CONNECTED    = 2'd2,
        MODE_DISCONNECTED = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MESSAGE_TIMEOUT   = 3'd0,
        CFG_INITIAL_TIMEOUT   = 3'd1,
        CFG_RECONNECT_TIMEOUT = 3'd2,
        CFG_MAX_DROPPED       = 3'd3,
        CFG_MIN_GOOD          = 3'd4,
        CFG_MAX_RECONNECTS    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TMO_W-1:0] frame_timeout_ms;
        logic [TMO_W-1:0] initial_timeout_ms;
        logic [TMO_W-1:0] reconnect_timeout_ms;
        logic [LIM_W-1:0] max_dropped_frames;
        logic [LIM_W-1:0] min_good_frames;
        logic [LIM_W-1:0] max_reconnects;
    } t_cfg;

    typedef struct packed {
        logic func;
        logic frame_parsed_ok;
        logic frame_is_channels;
        logic frame_type_supported;
    } t_item;

    // link_state sits in the lowest bits so the packed struct matches tdata
    typedef struct packed {
        logic  invalidate_channels;
        logic  forward_frame;
        logic  disconnect_event;
        logic  connect_event;
        logic  fatal_error;
        t_mode link_state;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// File: sv/rls_cfg.sv
// Configuration register file of the radio link supervisor.
`timescale 1ns / 1ps

module rls_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rls_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output rls_pkg::t_cfg                  o_cfg
);

    rls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_timeout_ms     <= rls_pkg::TMO_W'(100);
            r_cfg.initial_timeout_ms   <= rls_pkg::TMO_W'(5000);
            r_cfg.reconnect_timeout_ms <= rls_pkg::TMO_W'(1000);
            r_cfg.max_dropped_frames   <= rls_pkg::LIM_W'(10);
            r_cfg.min_good_frames      <= rls_pkg::LIM_W'(5);
            r_cfg.max_reconnects       <= rls_pkg::LIM_W'(3);
        end else if (i_cfg_we) begin
            case (rls_pkg::t_cfg_idx'(i_cfg_idx))
                rls_pkg::CFG_MESSAGE_TIMEOUT: begin
                    r_cfg.frame_timeout_ms <= i_cfg_wdata[rls_pkg::TMO_W-1:0];
                end
                rls_pkg::CFG_INITIAL_TIMEOUT: begin
                    r_cfg.initial_timeout_ms <= i_cfg_wdata[rls_pkg::TMO_W-1:0];
                end
                rls_pkg::CFG_RECONNECT_TIMEOUT: begin
                    r_cfg.reconnect_timeout_ms <= i_cfg_wdata[rls_pkg::TMO_W-1:0];
                end
                rls_pkg::CFG_MAX_DROPPED: begin
                    r_cfg.max_dropped_frames <= i_cfg_wdata[rls_pkg::LIM_W-1:0];
                end
                rls_pkg::CFG_MIN_GOOD: begin
                    r_cfg.min_good_frames <= i_cfg_wdata[rls_pkg::LIM_W-1:0];
                end
                rls_pkg::CFG_MAX_RECONNECTS: begin
                    r_cfg.max_reconnects <= i_cfg_wdata[rls_pkg::LIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/rls_core.sv
// Link state machine, saturating counters and timers of the supervisor.
`timescale 1ns / 1ps

module rls_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  rls_pkg::t_item   i_item,
    input  rls_pkg::t_cfg    i_cfg,
    output rls_pkg::t_result o_res
);

    localparam int TB = rls_pkg::TIMER_BITS;
    localparam int CB = rls_pkg::COUNT_BITS;
    localparam int CW = rls_pkg::CMP_W;

    rls_pkg::t_mode r_mode, n_mode;
    logic           r_shut, n_shut;
    logic [CB-1:0]  r_missed, n_missed;
    logic [CB-1:0]  r_good, n_good;
    logic [CB-1:0]  r_recon, n_recon;
    logic [TB-1:0]  r_wait, n_wait;
    logic [TB-1:0]  r_rtimer, n_rtimer;

    logic [TB-1:0]  wait_inc, rtimer_inc;
    logic [CB-1:0]  missed_inc, good_inc, recon_inc;
    logic [rls_pkg::TMO_W-1:0] wait_lim;
    logic           timeout, miss, miss_hit, good_hit, recon_lim, rtimer_hit;
    logic           conn, disc, fwd, inval;

    // decode
    always_comb begin
        wait_inc   = (r_wait == '1) ? r_wait : r_wait + 1'b1;
        rtimer_inc = (r_rtimer == '1) ? r_rtimer : r_rtimer + 1'b1;
        missed_inc = (r_missed == '1) ? r_missed : r_missed + 1'b1;
        good_inc   = (r_good == '1) ? r_good : r_good + 1'b1;
        recon_inc  = (r_recon == '1) ? r_recon : r_recon + 1'b1;
        wait_lim   = (r_mode == rls_pkg::MODE_UNKNOWN) ? i_cfg.initial_timeout_ms
                                                       : i_cfg.frame_timeout_ms;
        timeout    = !r_shut && (r_mode != rls_pkg::MODE_DISCONNECTED) && !i_item.func
                     && (CW'(wait_inc) >= CW'(wait_lim));
        miss       = timeout || (i_item.func && !i_item.frame_parsed_ok);
        miss_hit   = CW'(missed_inc) >= CW'(i_cfg.max_dropped_frames);
        good_hit   = CW'(good_inc) >= CW'(i_cfg.min_good_frames);
        recon_lim  = CW'(r_recon) >= CW'(i_cfg.max_reconnects);
        rtimer_hit = CW'(rtimer_inc) >= CW'(i_cfg.reconnect_timeout_ms);
    end

    // next state
    always_comb begin
        n_mode   = r_mode;
        n_shut   = r_shut;
        n_missed = r_missed;
        n_good   = r_good;
        n_recon  = r_recon;
        n_wait   = r_wait;
        n_rtimer = r_rtimer;
        if (!r_shut) begin
            if (r_mode != rls_pkg::MODE_DISCONNECTED) begin
                n_wait = (i_item.func || timeout) ? '0 : wait_inc;
            end
            case (r_mode)
                rls_pkg::MODE_UNKNOWN: begin
                    if (timeout) begin
                        n_shut = 1'b1;
                        n_mode = rls_pkg::MODE_DISCONNECTED;
                    end else if (i_item.func && i_item.frame_parsed_ok
                                 && i_item.frame_is_channels) begin
                        n_mode = rls_pkg::MODE_CONNECTING;
                    end
                end
                rls_pkg::MODE_CONNECTING, rls_pkg::MODE_CONNECTED: begin
                    if (miss) begin
                        n_missed = missed_inc;
                        if (r_mode == rls_pkg::MODE_CONNECTING) begin
                            n_good = '0;
                        end
                        if (miss_hit) begin
                            n_mode   = rls_pkg::MODE_DISCONNECTED;
                            n_missed = '0;
                            n_good   = '0;
                            n_rtimer = '0;
                            n_wait   = '0;
                            n_shut   = recon_lim;
                        end
                    end else if (r_mode == rls_pkg::MODE_CONNECTING) begin
                        if (i_item.func) begin
                            n_good = good_inc;
                            if (good_hit) begin
                                n_mode   = rls_pkg::MODE_CONNECTED;
                                n_missed = '0;
                                n_good   = '0;
                            end
                        end
                    end else if (i_item.func && i_item.frame_type_supported) begin
                        n_missed = '0;
                    end
                end
                default: begin
                    if (i_item.func) begin
                        if (i_item.frame_parsed_ok) begin
                            n_recon  = recon_inc;
                            n_rtimer = '0;
                            n_wait   = '0;
                            n_mode   = rls_pkg::MODE_CONNECTING;
                        end
                    end else begin
                        n_rtimer = rtimer_inc;
                        if (rtimer_hit) begin
                            n_shut = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    // events
    always_comb begin
        conn  = 1'b0;
        disc  = 1'b0;
        fwd   = 1'b0;
        inval = 1'b0;
        if (!r_shut) begin
            case (r_mode)
                rls_pkg::MODE_UNKNOWN: begin
                    disc = timeout;
                end
                rls_pkg::MODE_CONNECTING: begin
                    conn = !miss && i_item.func && good_hit;
                    disc = miss && miss_hit && recon_lim;
                end
                rls_pkg::MODE_CONNECTED: begin
                    fwd   = !miss && i_item.func && i_item.frame_type_supported;
                    disc  = miss && miss_hit;
                    inval = miss && miss_hit;
                end
                default: begin
                    disc = !i_item.func && rtimer_hit;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= rls_pkg::MODE_UNKNOWN;
            r_shut   <= 1'b0;
            r_missed <= '0;
            r_good   <= '0;
            r_recon  <= '0;
            r_wait   <= '0;
            r_rtimer <= '0;
        end else if (i_en) begin
            r_mode   <= n_mode;
            r_shut   <= n_shut;
            r_missed <= n_missed;
            r_good   <= n_good;
            r_recon  <= n_recon;
            r_wait   <= n_wait;
            r_rtimer <= n_rtimer;
        end
    end

    assign o_res.link_state          = n_mode;
    assign o_res.fatal_error         = n_shut;
    assign o_res.connect_event       = conn;
    assign o_res.disconnect_event    = disc;
    assign o_res.forward_frame       = fwd;
    assign o_res.invalidate_channels = inval;

endmodule

// File: sv/radio_link_supervisor.sv
// Top level of the radio link supervisor: stream channels, pipeline and checks.
//
// Input stream (s_axis): one transfer per 1 ms tick or frame report; tuser
// selects the kind (0 tick, 1 frame), tdata carries the frame flags.
// Output stream (m_axis): exactly one result transfer per input transfer,
// in order: link state, fatal error and the event pulses of that item.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx at the
// clock edge; write only while no transfer is in flight.
// Pipeline: the input register loads at the input transfer, the result register
// loads from it when the output can take it, and the result transfers from there.
// Throughput: one transfer per cycle while m_axis_tready is high; the state update
// is a single pass through the link state machine between the two registers.
// Reset: registers return to defaults, link state unknown, counters and
// timers cleared, pipeline empty.
// Stall: while m_axis_tready is low a waiting result holds in the result register; one
// more item is taken into the input register, then s_axis_tready drops.
`timescale 1ns / 1ps

module radio_link_supervisor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // parsed_ok, is_channels, supported
    input  logic [0:0]                     s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // link_state[1:0], fatal_error, connect_event, disconnect_event,
    // forward_frame, invalidate_channels
    output logic [7:0]                     m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rls_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    rls_pkg::t_cfg    w_cfg;
    rls_pkg::t_item   r_in;
    rls_pkg::t_result r_out;
    rls_pkg::t_result w_res;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_take;
    logic             w_adv;
    logic             w_s_xfer;

    assign w_take        = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_take;
    assign s_axis_tready = !r_in_valid || w_take;
    assign w_s_xfer      = s_axis_tvalid && s_axis_tready;

    rls_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    rls_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in.func                 <= s_axis_tuser[0];
            r_in.frame_parsed_ok      <= s_axis_tdata[0];
            r_in.frame_is_channels    <= s_axis_tdata[1];
            r_in.frame_type_supported <= s_axis_tdata[2];
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - rls_pkg::RES_W){1'b0}}, r_out};

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled while pipeline has room");

    a_connect_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.connect_event || r_out.forward_frame))
        |-> (r_out.link_state == rls_pkg::MODE_CONNECTED && !r_out.fatal_error))
        else $error("connect or forward outside connected state");

    a_disconnect_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.disconnect_event || r_out.fatal_error))
        |-> (r_out.link_state == rls_pkg::MODE_DISCONNECTED))
        else $error("disconnect or fatal without disconnected state");

    a_invalidate_with_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.invalidate_channels) |-> r_out.disconnect_event)
        else $error("invalidate without disconnect event");

    a_fatal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_out_valid && r_out.fatal_error) |=> r_out.fatal_error)
        else $error("fatal error cleared without reset");

endmodule

// File: dv/tb_radio_link_supervisor.sv
// Testbench for radio_link_supervisor: directed and random traffic vs. a link-state model.
`timescale 1ns / 1ps

module tb_radio_link_supervisor;

    localparam int CYCLE_LIMIT = 1000000;
    localparam rls_pkg::t_item TICK = '0;

    logic                           i_clk;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;  // parsed_ok, is_channels, supported
    logic [0:0]                     s_axis_tuser  = '0;  // func
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // link_state[1:0], fatal_error, connect_event, disconnect_event,
    // forward_frame, invalidate_channels
    logic [7:0]                     m_axis_tdata;
    logic                           i_cfg_we      = 1'b0;
    logic [rls_pkg::CFG_IDX_W-1:0]  i_cfg_idx     = rls_pkg::CFG_MESSAGE_TIMEOUT;
    logic [rls_pkg::CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    bit hold_off  = 1'b0;
    int send_calm = 0;
    int cycles    = 0;

    radio_link_supervisor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    class link_status_board;
        rls_pkg::t_cfg                  cfg;
        rls_pkg::t_mode                 mode;
        bit                             down;
        logic [rls_pkg::COUNT_BITS-1:0] missed, good, reconnects;
        logic [rls_pkg::TIMER_BITS-1:0] wait_ms, recon_ms;
        rls_pkg::t_result               status;
        rls_pkg::t_result               expected_status[$];
        int                             errors;
        int                             results_seen;

        function new();
            cfg.frame_timeout_ms     = 16'd100;
            cfg.initial_timeout_ms   = 16'd5000;
            cfg.reconnect_timeout_ms = 16'd1000;
            cfg.max_dropped_frames   = 8'd10;
            cfg.min_good_frames      = 8'd5;
            cfg.max_reconnects       = 8'd3;
            mode         = rls_pkg::MODE_UNKNOWN;
            down         = 1'b0;
            missed       = '0;
            good         = '0;
            reconnects   = '0;
            wait_ms      = '0;
            recon_ms     = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void shut_link();
            down = 1'b1;
            mode = rls_pkg::MODE_DISCONNECTED;
            status.disconnect_event = 1'b1;
        endfunction

        function void drop_link();
            mode     = rls_pkg::MODE_DISCONNECTED;
            missed   = '0;
            good     = '0;
            recon_ms = '0;
            wait_ms  = '0;
            if (reconnects >= cfg.max_reconnects) shut_link();
        endfunction

        function void count_miss();
            if (missed != '1) missed++;
        endfunction

        // one accepted transfer -> one expected status
        function void take_item(rls_pkg::t_item it);
            bit                             tmo;
            logic [rls_pkg::TIMER_BITS-1:0] lim;
            status = '0;
            tmo    = 1'b0;
            if (!down) begin
                if (mode != rls_pkg::MODE_DISCONNECTED) begin
                    if (it.func) begin
                        wait_ms = '0;
                    end else begin
                        lim = (mode == rls_pkg::MODE_UNKNOWN) ? cfg.initial_timeout_ms
                                                              : cfg.frame_timeout_ms;
                        if (wait_ms != '1) wait_ms++;
                        if (wait_ms >= lim) begin
                            tmo     = 1'b1;
                            wait_ms = '0;
                        end
                    end
                end
                case (mode)
                    rls_pkg::MODE_UNKNOWN: begin
                        if (tmo) shut_link();
                        else if (it.func && it.frame_parsed_ok && it.frame_is_channels)
                            mode = rls_pkg::MODE_CONNECTING;
                    end
                    rls_pkg::MODE_CONNECTING: begin
                        if (tmo || (it.func && !it.frame_parsed_ok)) begin
                            count_miss();
                            good = '0;
                            if (missed >= cfg.max_dropped_frames) drop_link();
                        end else if (it.func) begin
                            if (good != '1) good++;
                            if (good >= cfg.min_good_frames) begin
                                mode                 = rls_pkg::MODE_CONNECTED;
                                status.connect_event = 1'b1;
                                missed               = '0;
                                good                 = '0;
                            end
                        end
                    end
                    rls_pkg::MODE_CONNECTED: begin
                        if (tmo || (it.func && !it.frame_parsed_ok)) begin
                            count_miss();
                            if (missed >= cfg.max_dropped_frames) begin
                                status.disconnect_event    = 1'b1;
                                status.invalidate_channels = 1'b1;
                                drop_link();
                            end
                        end else if (it.func && it.frame_type_supported) begin
                            status.forward_frame = 1'b1;
                            missed               = '0;
                        end
                    end
                    default: begin
                        if (it.func) begin
                            if (it.frame_parsed_ok) begin
                                if (reconnects != '1) reconnects++;
                                recon_ms = '0;
                                wait_ms  = '0;
                                mode     = rls_pkg::MODE_CONNECTING;
                            end
                        end else begin
                            if (recon_ms != '1) recon_ms++;
                            if (recon_ms >= cfg.reconnect_timeout_ms) shut_link();
                        end
                    end
                endcase
            end
            status.link_state  = mode;
            status.fatal_error = down;
            expected_status.push_back(status);
        endfunction

        task report_mismatch(input string what, input logic [7:0] got_v,
                             input logic [7:0] exp_v);
            $display("MISMATCH status %0d %s: got %0h, expected %0h",
                     results_seen, what, got_v, exp_v);
            errors++;
        endtask

        task check_status(input logic [7:0] data);
            rls_pkg::t_result got, exp;
            results_seen++;
            got = rls_pkg::t_result'(data[rls_pkg::RES_W-1:0]);
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected transfer", data, 8'h0);
            end else begin
                exp = expected_status.pop_front();
                if (got.link_state !== exp.link_state)
                    report_mismatch("link_state", 8'(got.link_state), 8'(exp.link_state));
                if (got.fatal_error !== exp.fatal_error)
                    report_mismatch("fatal_error", 8'(got.fatal_error), 8'(exp.fatal_error));
                if (got.connect_event !== exp.connect_event)
                    report_mismatch("connect_event", 8'(got.connect_event),
                                    8'(exp.connect_event));
                if (got.disconnect_event !== exp.disconnect_event)
                    report_mismatch("disconnect_event", 8'(got.disconnect_event),
                                    8'(exp.disconnect_event));
                if (got.forward_frame !== exp.forward_frame)
                    report_mismatch("forward_frame", 8'(got.forward_frame),
                                    8'(exp.forward_frame));
                if (got.invalidate_channels !== exp.invalidate_channels)
                    report_mismatch("invalidate_channels", 8'(got.invalidate_channels),
                                    8'(exp.invalidate_channels));
            end
        endtask
    endclass

    link_status_board sb = new();

    function automatic rls_pkg::t_cfg link_cfg(int msg, int init, int recon, int drop,
                                               int good, int maxr);
        rls_pkg::t_cfg c;
        c.frame_timeout_ms     = rls_pkg::TMO_W'(msg);
        c.initial_timeout_ms   = rls_pkg::TMO_W'(init);
        c.reconnect_timeout_ms = rls_pkg::TMO_W'(recon);
        c.max_dropped_frames   = rls_pkg::LIM_W'(drop);
        c.min_good_frames      = rls_pkg::LIM_W'(good);
        c.max_reconnects       = rls_pkg::LIM_W'(maxr);
        return c;
    endfunction

    function automatic rls_pkg::t_item frm(bit parsed, bit chans, bit supp);
        return {1'b1, parsed, chans, supp};
    endfunction

    function automatic rls_pkg::t_item rand_item(int p_tick, int p_parsed, int p_chan,
                                                 int p_supp);
        rls_pkg::t_item it;
        it.func                 = ($urandom_range(0, 99) >= p_tick);
        it.frame_parsed_ok      = ($urandom_range(0, 99) < p_parsed);
        it.frame_is_channels    = ($urandom_range(0, 99) < p_chan);
        it.frame_type_supported = ($urandom_range(0, 99) < p_supp);
        return it;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones, occasional calm runs
    function int next_gap();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input rls_pkg::t_item it, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= {5'b0, it.frame_type_supported, it.frame_is_channels,
                          it.frame_parsed_ok};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_item(it);
    endtask

    // waits until every status has come back, then writes all registers
    task automatic settle_and_configure(input rls_pkg::t_cfg c);
        rls_pkg::t_cfg_idx              idx;
        logic [rls_pkg::CFG_DATA_W-1:0] val;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (4) @(posedge i_clk);
        idx = idx.first();
        for (int k = 0; k < idx.num(); k++) begin
            case (idx)
                rls_pkg::CFG_MESSAGE_TIMEOUT:
                    val = rls_pkg::CFG_DATA_W'(c.frame_timeout_ms);
                rls_pkg::CFG_INITIAL_TIMEOUT:
                    val = rls_pkg::CFG_DATA_W'(c.initial_timeout_ms);
                rls_pkg::CFG_RECONNECT_TIMEOUT:
                    val = rls_pkg::CFG_DATA_W'(c.reconnect_timeout_ms);
                rls_pkg::CFG_MAX_DROPPED:
                    val = rls_pkg::CFG_DATA_W'(c.max_dropped_frames);
                rls_pkg::CFG_MIN_GOOD:
                    val = rls_pkg::CFG_DATA_W'(c.min_good_frames);
                default:
                    val = rls_pkg::CFG_DATA_W'(c.max_reconnects);
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= val;
            @(posedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        sb.cfg = c;
    endtask

    task automatic run_phase(input rls_pkg::t_cfg c, input int n, input int p_tick,
                             input int p_parsed, input int p_chan, input int p_supp);
        settle_and_configure(c);
        repeat (n) send_item(rand_item(p_tick, p_parsed, p_chan, p_supp), next_gap());
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : status_sink
        int stall, calm, r;
        stall = 0;
        calm  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_status(m_axis_tdata);
            if (hold_off || stall > 0) begin
                if (stall > 0) stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (calm > 0) begin
                    calm--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2) calm = $urandom_range(30, 120);
                    else if (r < 20) stall = $urandom_range(1, 3);
                    else if (r < 23) stall = $urandom_range(10, 40);
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering: fills the pipe
    initial begin : long_hold
        do @(posedge i_clk); while (sb.results_seen < 120);
        hold_off <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : stimulus
        rls_pkg::t_item directed[$];
        rls_pkg::t_cfg  final_cfg;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unknown: ignored frames, then a channel frame; connecting with a miss;
        // connected: forward, unsupported, timeout and drop; reconnect; drop from connecting
        directed = {TICK, frm(0, 1, 1), frm(1, 0, 1), rls_pkg::t_item'(4'b0111),
                    frm(1, 1, 1), frm(1, 0, 0), frm(0, 0, 0), frm(1, 0, 1), frm(1, 1, 0),
                    frm(1, 1, 1), frm(1, 0, 0), TICK, TICK, TICK, frm(0, 1, 1),
                    TICK, frm(0, 1, 1), frm(1, 0, 0), TICK, TICK, TICK,
                    frm(0, 0, 0), frm(1, 1, 1)};
        settle_and_configure(link_cfg(3, 40, 20, 2, 2, 200));
        foreach (directed[k]) send_item(directed[k], next_gap());
        s_axis_tvalid <= 1'b0;

        run_phase(link_cfg(4, 65535, 30, 3, 3, 255), 350, 40, 80, 50, 70);
        // every tick out of the disconnected state times out; single frames connect and drop
        run_phase(link_cfg(1, 1, 65535, 1, 1, 255), 200, 30, 70, 50, 60);
        // only unparsed frames: climb to the largest drop limit
        run_phase(link_cfg(65535, 5000, 65535, 255, 2, 255), 320, 5, 0, 50, 50);
        // only parsed frames: climb to the largest good-frame limit
        run_phase(link_cfg(65535, 100, 1000, 255, 255, 255), 340, 15, 100, 50, 50);

        // last phase ends in shutdown one way or another
        case ($urandom_range(0, 2))
            0:       final_cfg = link_cfg(3, 5000, 65535, 2, 2, 0);
            1:       final_cfg = link_cfg(3, 5000, 4, 2, 2, 255);
            default: final_cfg = link_cfg(3, 5000, 65535, 2, 2,
                                          (sb.reconnects == '1) ? 255 : sb.reconnects + 1);
        endcase
        run_phase(final_cfg, 440, 40, 75, 50, 60);

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
